FILE: rtl/bbcr_pkg.sv
// Package for the bounding box crop and rescale block.
// Holds shared payload structs, codes, the controller state type and size constants.
// No dependencies.
`default_nettype none

package bbcr_pkg;

   // Default image side and the largest side the design supports
   localparam int SIDE_DEFAULT = 28;
   localparam int SIDE_MAX     = 64;
   localparam int COORD_MAX_W  = $clog2(SIDE_MAX);

   // Request action codes
   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_READ = 1'b1;

   // Request transaction payload
   typedef struct packed {
      logic       action;
      logic [7:0] pixel_in;
   } req_item_type;

   // Result transaction payload
   typedef struct packed {
      logic [7:0] pixel_out;
      logic       last_pixel;
   } rsp_item_type;

   // Box tracker status; coordinates are zero-extended to the widest supported side
   typedef struct packed {
      logic                   any_ink;
      logic                   load_first;
      logic [COORD_MAX_W-1:0] top;
      logic [COORD_MAX_W-1:0] bottom;
      logic [COORD_MAX_W-1:0] left;
      logic [COORD_MAX_W-1:0] right;
   } box_status_type;

   // Controller states
   typedef enum logic {
      ST_IDLE,
      ST_READ
   } state_type;

endpackage

`default_nettype wire

FILE: rtl/bbcr_store.sv
// Image store: single write port, single read port with registered read data.
// Depends on nothing but its parameters.
`default_nettype none

module bbcr_store #(
   parameter int DEPTH = 784,
   parameter int AW    = 10
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [7:0]    wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output      logic [7:0]    rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, registered read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/bbcr_box.sv
// Load position counter and bounding box tracker of nonzero pixels.
// Depends on bbcr_pkg.
`default_nettype none

module bbcr_box #(
   parameter int SIDE = bbcr_pkg::SIDE_DEFAULT,
   localparam int AREA = SIDE * SIDE,
   localparam int AW   = $clog2(AREA),
   localparam int CW   = $clog2(SIDE)
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    load_en,
   input  wire logic [7:0]              pixel,
   output      logic [AW-1:0]           load_addr,
   output      bbcr_pkg::box_status_type status
);

   logic [AW-1:0] addr_ff, addr_in;
   logic [CW-1:0] row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;
   logic [CW-1:0] top_ff, top_in;
   logic [CW-1:0] bottom_ff, bottom_in;
   logic [CW-1:0] left_ff, left_in;
   logic [CW-1:0] right_ff, right_in;
   logic          ink_ff, ink_in;

   logic          first;
   logic          ink_base;
   logic [CW-1:0] top_base, bottom_base, left_base, right_base;

   assign first = (addr_ff == '0);

   // Raster position of the next load
   always_comb begin
      addr_in = addr_ff;
      row_in  = row_ff;
      col_in  = col_ff;
      if (load_en) begin
         if (addr_ff == AW'(AREA - 1)) begin
            addr_in = '0;
            row_in  = '0;
            col_in  = '0;
         end else begin
            addr_in = addr_ff + 1'b1;
            if (col_ff == CW'(SIDE - 1)) begin
               col_in = '0;
               row_in = row_ff + 1'b1;
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
      end
   end

   // Box update; a load at position zero starts from an empty box
   always_comb begin
      ink_base    = first ? 1'b0 : ink_ff;
      top_base    = first ? '0 : top_ff;
      bottom_base = first ? '0 : bottom_ff;
      left_base   = first ? '0 : left_ff;
      right_base  = first ? '0 : right_ff;

      ink_in    = ink_ff;
      top_in    = top_ff;
      bottom_in = bottom_ff;
      left_in   = left_ff;
      right_in  = right_ff;
      if (load_en) begin
         ink_in    = ink_base;
         top_in    = top_base;
         bottom_in = bottom_base;
         left_in   = left_base;
         right_in  = right_base;
         if (pixel != 8'd0) begin
            ink_in = 1'b1;
            if (!ink_base) begin
               top_in    = row_ff;
               bottom_in = row_ff;
               left_in   = col_ff;
               right_in  = col_ff;
            end else begin
               if (row_ff < top_base)    top_in    = row_ff;
               if (row_ff > bottom_base) bottom_in = row_ff;
               if (col_ff < left_base)   left_in   = col_ff;
               if (col_ff > right_base)  right_in  = col_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff   <= '0;
         row_ff    <= '0;
         col_ff    <= '0;
         top_ff    <= '0;
         bottom_ff <= '0;
         left_ff   <= '0;
         right_ff  <= '0;
         ink_ff    <= 1'b0;
      end else begin
         addr_ff   <= addr_in;
         row_ff    <= row_in;
         col_ff    <= col_in;
         top_ff    <= top_in;
         bottom_ff <= bottom_in;
         left_ff   <= left_in;
         right_ff  <= right_in;
         ink_ff    <= ink_in;
      end
   end

   assign load_addr         = addr_ff;
   assign status.any_ink    = ink_ff;
   assign status.load_first = first;
   assign status.top        = bbcr_pkg::COORD_MAX_W'(top_ff);
   assign status.bottom     = bbcr_pkg::COORD_MAX_W'(bottom_ff);
   assign status.left       = bbcr_pkg::COORD_MAX_W'(left_ff);
   assign status.right      = bbcr_pkg::COORD_MAX_W'(right_ff);

endmodule

`default_nettype wire

FILE: rtl/bbcr_sampler.sv
// Four-stage source address unit: scale products, reciprocal divide by SIDE,
// quotient correction plus box offset, and the final raster address. Depends on bbcr_pkg.
`default_nettype none

module bbcr_sampler #(
   parameter int SIDE = bbcr_pkg::SIDE_DEFAULT,
   localparam int AREA = SIDE * SIDE,
   localparam int AW   = $clog2(AREA),
   localparam int CW   = $clog2(SIDE),
   localparam int HW   = $clog2(SIDE + 1)
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_valid,
   input  wire logic [CW-1:0]           y,
   input  wire logic [CW-1:0]           x,
   input  wire bbcr_pkg::box_status_type status,
   output      logic                    out_valid,
   output      logic [AW-1:0]           out_addr
);

   // Reciprocal of SIDE; a floor estimate is at most one below the true quotient
   localparam int     SH      = 2 * AW;
   localparam int     PW      = AW + SH;
   localparam longint RECIP_L = (longint'(1) << SH) / SIDE;
   localparam logic [SH-1:0] RECIP = SH'(RECIP_L);

   logic [CW-1:0] top, bottom, left, right;
   logic [HW-1:0] height, width;

   logic          s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic [AW-1:0] py1_ff, px1_ff, py2_ff, px2_ff;
   logic [CW-1:0] top1_ff, left1_ff, top2_ff, left2_ff;
   logic [CW-1:0] qy2_ff, qx2_ff;
   logic [CW-1:0] sr3_ff, sc3_ff;
   logic [AW-1:0] addr4_ff;

   logic [PW-1:0] prod_y, prod_x;
   logic [AW-1:0] rem_y, rem_x;
   logic [CW-1:0] qy, qx;

   assign top    = CW'(status.top);
   assign bottom = CW'(status.bottom);
   assign left   = CW'(status.left);
   assign right  = CW'(status.right);
   assign height = HW'(bottom) - HW'(top) + 1'b1;
   assign width  = HW'(right) - HW'(left) + 1'b1;

   // Valid pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   // Stage 1: position times box extent
   always_ff @(posedge clock) begin
      py1_ff   <= AW'(AW'(y) * AW'(height));
      px1_ff   <= AW'(AW'(x) * AW'(width));
      top1_ff  <= top;
      left1_ff <= left;
   end

   // Stage 2: quotient estimate by reciprocal multiply
   assign prod_y = PW'(py1_ff) * PW'(RECIP);
   assign prod_x = PW'(px1_ff) * PW'(RECIP);

   always_ff @(posedge clock) begin
      py2_ff   <= py1_ff;
      px2_ff   <= px1_ff;
      qy2_ff   <= prod_y[SH +: CW];
      qx2_ff   <= prod_x[SH +: CW];
      top2_ff  <= top1_ff;
      left2_ff <= left1_ff;
   end

   // Stage 3: one correction step, then offset into the box
   assign rem_y = py2_ff - AW'(AW'(qy2_ff) * AW'(SIDE));
   assign rem_x = px2_ff - AW'(AW'(qx2_ff) * AW'(SIDE));
   assign qy    = qy2_ff + CW'(rem_y >= AW'(SIDE));
   assign qx    = qx2_ff + CW'(rem_x >= AW'(SIDE));

   always_ff @(posedge clock) begin
      sr3_ff <= qy + top2_ff;
      sc3_ff <= qx + left2_ff;
   end

   // Stage 4: raster address of the source pixel
   always_ff @(posedge clock) begin
      addr4_ff <= AW'(AW'(sr3_ff) * AW'(SIDE)) + AW'(sc3_ff);
   end

   assign out_valid = s4_valid_ff;
   assign out_addr  = addr4_ff;

endmodule

`default_nettype wire

FILE: rtl/bounding_box_crop_and_rescale.sv
// Bounding box crop and nearest-neighbor rescale of a square grayscale image.
// Load transaction: does not raise busy; a new transaction may follow in the next cycle.
// Read transaction: the result passes through the four-stage address unit and the registered image
// store read; busy holds off further transactions until the result is strobed.
// Synchronous active-high reset clears positions and box; the image store is not cleared.
// The receiver cannot stall; each result is valid for one cycle.
`default_nettype none

module bounding_box_crop_and_rescale #(
   parameter int SIDE = bbcr_pkg::SIDE_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output      logic                  busy,
   input  wire bbcr_pkg::req_item_type req_item,
   output      logic                  rsp_valid,
   output      bbcr_pkg::rsp_item_type rsp_item
);

   localparam int AREA = SIDE * SIDE;
   localparam int AW   = $clog2(AREA);
   localparam int CW   = $clog2(SIDE);

   bbcr_pkg::state_type      state_ff, state_in;
   bbcr_pkg::box_status_type status;

   logic          accept, load_en, read_en;
   logic [AW-1:0] load_addr;
   logic          samp_valid;
   logic [AW-1:0] samp_addr;
   logic [7:0]    rd_data;
   logic          rd_valid_ff;
   logic [CW-1:0] read_row_ff, read_row_in;
   logic [CW-1:0] read_col_ff, read_col_in;
   logic          last_ff, last_in;
   logic          read_last;

   assign accept  = start && !busy;
   assign load_en = accept && (req_item.action == bbcr_pkg::ACT_LOAD);
   assign read_en = accept && (req_item.action == bbcr_pkg::ACT_READ);

   // Box tracker and load position
   bbcr_box #(
      .SIDE (SIDE)
   ) u_box (
      .clock     (clock),
      .reset     (reset),
      .load_en   (load_en),
      .pixel     (req_item.pixel_in),
      .load_addr (load_addr),
      .status    (status)
   );

   // Source address unit
   bbcr_sampler #(
      .SIDE (SIDE)
   ) u_sampler (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (read_en),
      .y         (read_row_ff),
      .x         (read_col_ff),
      .status    (status),
      .out_valid (samp_valid),
      .out_addr  (samp_addr)
   );

   // Image store
   bbcr_store #(
      .DEPTH (AREA),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (load_en),
      .wr_addr (load_addr),
      .wr_data (req_item.pixel_in),
      .rd_en   (samp_valid),
      .rd_addr (samp_addr),
      .rd_data (rd_data)
   );

   // Read position; a load that starts a new image rewinds it
   assign read_last = (read_row_ff == CW'(SIDE - 1)) && (read_col_ff == CW'(SIDE - 1));

   always_comb begin
      read_row_in = read_row_ff;
      read_col_in = read_col_ff;
      last_in     = last_ff;
      if (load_en && status.load_first) begin
         read_row_in = '0;
         read_col_in = '0;
      end else if (read_en) begin
         last_in = read_last;
         if (read_last) begin
            read_row_in = '0;
            read_col_in = '0;
         end else if (read_col_ff == CW'(SIDE - 1)) begin
            read_col_in = '0;
            read_row_in = read_row_ff + 1'b1;
         end else begin
            read_col_in = read_col_ff + 1'b1;
         end
      end
   end

   // Handshake: busy while a read is in flight until its result is strobed
   assign busy = (state_ff == bbcr_pkg::ST_READ) && !rd_valid_ff;

   // Controller next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bbcr_pkg::ST_IDLE: begin
            if (read_en) state_in = bbcr_pkg::ST_READ;
         end
         bbcr_pkg::ST_READ: begin
            if (rd_valid_ff && !read_en) state_in = bbcr_pkg::ST_IDLE;
         end
         default: begin
            state_in = bbcr_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= bbcr_pkg::ST_IDLE;
         read_row_ff <= '0;
         read_col_ff <= '0;
         last_ff     <= 1'b0;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         read_row_ff <= read_row_in;
         read_col_ff <= read_col_in;
         last_ff     <= last_in;
         rd_valid_ff <= samp_valid;
      end
   end

   // Result; an image without ink reads as zero
   assign rsp_valid          = rd_valid_ff;
   assign rsp_item.pixel_out = status.any_ink ? rd_data : 8'd0;
   assign rsp_item.last_pixel = last_ff;

`ifndef ASSERT_OFF
   // A result only arrives for a read in flight
   a_rsp_in_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (state_ff == bbcr_pkg::ST_READ))
      else $error("result strobe outside a read");

   // An accepted read holds off the next transaction
   a_read_busy: assert property (@(posedge clock) disable iff (reset)
      read_en |=> busy)
      else $error("busy not raised after read acceptance");

   // One result per read, never on consecutive cycles
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe repeated");

   // Box is ordered once ink is seen, and cleared otherwise
   a_box_order: assert property (@(posedge clock) disable iff (reset)
      status.any_ink |-> (status.top <= status.bottom) && (status.left <= status.right))
      else $error("bounding box out of order");

   a_box_empty: assert property (@(posedge clock) disable iff (reset)
      !status.any_ink |-> (status.top == '0) && (status.bottom == '0) &&
                          (status.left == '0) && (status.right == '0))
      else $error("empty image with nonzero box");
`endif

endmodule

`default_nettype wire
